FILE: rtl/gtlm_pkg.sv
package gtlm_pkg;

   localparam int unsigned GENOTYPES  = 10;
   localparam int unsigned HALF_GT    = 5;
   localparam int unsigned LK_W       = 8;
   localparam int unsigned POS_W      = 31;
   localparam int unsigned HALF_W     = 40;
   localparam int unsigned DP_IN_W    = 24;
   localparam int unsigned DEPTH_W    = 26;
   localparam int unsigned LLK_IN_W   = 16;
   localparam int unsigned LLK_W      = 18;
   localparam int unsigned TOTAL_W    = 27;
   localparam int unsigned SQ_W       = 16;
   localparam int unsigned PA_W       = 42;
   localparam int unsigned NUM_W      = 43;
   localparam int unsigned TDATA_W    = 168;
   localparam int unsigned CSR_W      = 64;

   localparam logic [1:0] CSR_QUALITY   = 2'd0;
   localparam logic [1:0] CSR_MIN_DEPTH = 2'd1;
   localparam logic [1:0] CSR_MAX_DEPTH = 2'd2;

   localparam logic [31:0] QUALITY_RST   = 32'h1E1E1E1E;
   localparam logic [63:0] MIN_DEPTH_RST = 64'h0001000100010001;
   localparam logic [63:0] MAX_DEPTH_RST = 64'h00C800C800C800C8;

   typedef struct packed {
      logic                used;
      logic [3:0]          base;
      logic [POS_W-1:0]    pos;
      logic [HALF_W-1:0]   lk0;
      logic [HALF_W-1:0]   lk1;
      logic [7:0]          mq;
      logic [DP_IN_W-1:0]  dp;
      logic [LLK_IN_W-1:0] llk;
      logic                last;
   } entry_type;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b00000001,
      ST_LK   = 8'b00000010,
      ST_MUL1 = 8'b00000100,
      ST_MUL2 = 8'b00001000,
      ST_MUL3 = 8'b00010000,
      ST_DIV  = 8'b00100000,
      ST_SQRT = 8'b01000000,
      ST_FIN  = 8'b10000000
   } back_state_type;

endpackage

FILE: rtl/gtlm_front.sv
module gtlm_front import gtlm_pkg::*; #(
   parameter int unsigned MAX_SOURCES = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   output entry_type          entry
);

   logic [31:0] qlim_ff, qlim_in;
   logic [63:0] dmin_ff, dmin_in;
   logic [63:0] dmax_ff, dmax_in;
   logic [1:0]  src;
   logic [7:0]  qlim;
   logic [15:0] dmin, dmax;
   logic        src_ok;

   always_comb begin
      qlim_in = qlim_ff;
      dmin_in = dmin_ff;
      dmax_in = dmax_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUALITY:   qlim_in = csr_wdata[31:0];
            CSR_MIN_DEPTH: dmin_in = csr_wdata;
            CSR_MAX_DEPTH: dmax_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qlim_ff <= QUALITY_RST;
         dmin_ff <= MIN_DEPTH_RST;
         dmax_ff <= MAX_DEPTH_RST;
      end else begin
         qlim_ff <= qlim_in;
         dmin_ff <= dmin_in;
         dmax_ff <= dmax_in;
      end
   end

   assign src    = req_tdata[1:0];
   assign qlim   = qlim_ff[8*src +: 8];
   assign dmin   = dmin_ff[16*src +: 16];
   assign dmax   = dmax_ff[16*src +: 16];
   assign src_ok = 32'(src) < MAX_SOURCES;

   always_comb begin
      entry.base = req_tdata[5:2];
      entry.pos  = req_tdata[36:6];
      entry.lk0  = req_tdata[76:37];
      entry.lk1  = req_tdata[116:77];
      entry.mq   = req_tdata[124:117];
      entry.dp   = req_tdata[148:125];
      entry.llk  = req_tdata[164:149];
      entry.last = req_tlast;
      entry.used = src_ok && (entry.mq >= qlim) && (entry.dp >= {8'd0, dmin})
                   && ((dmax == 16'd0) || (entry.dp <= {8'd0, dmax}));
   end

endmodule

FILE: rtl/gtlm_queue.sv
module gtlm_queue import gtlm_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_data
);

   entry_type  slot_ff [2];
   entry_type  slot_in [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == 2'd2;
   assign head_valid = cnt_ff != 2'd0;
   assign head_data  = slot_ff[rd_ff];

   always_comb begin
      slot_in = slot_ff;
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         slot_in[wr_ff] = push_data;
         wr_in          = ~wr_ff;
      end
      if (pop) rd_in = ~rd_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid)) else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");

endmodule

FILE: rtl/gtlm_back.sv
module gtlm_back import gtlm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  entry_type          head_data,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata
);

   back_state_type       state_ff, state_in;
   entry_type            ent_ff, ent_in;
   logic [LK_W-1:0]      acc_lk_ff [GENOTYPES];
   logic [LK_W-1:0]      acc_lk_in [GENOTYPES];
   logic [DEPTH_W-1:0]   acc_dp_ff, acc_dp_in;
   logic [7:0]           acc_q_ff, acc_q_in;
   logic [LLK_W-1:0]     acc_llk_ff, acc_llk_in;
   logic [3:0]           base_ff, base_in;
   logic                 open_ff, open_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [SQ_W-1:0]      sqa_ff, sqa_in, sqb_ff, sqb_in;
   logic [PA_W-1:0]      pa_ff, pa_in;
   logic [TOTAL_W-1:0]   rem_ff, rem_in;
   logic [SQ_W-1:0]      quo_ff, quo_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic [7:0]           root_ff, root_in;
   logic                 rv_ff, rv_in;
   logic [TDATA_W-1:0]   rd_ff, rd_in;

   logic [LK_W:0]        sums [GENOTYPES];
   logic [LK_W:0]        mn, diff;
   logic [LLK_W:0]       llk_sum;
   logic [SQ_W+DP_IN_W-1:0] prod;
   logic [NUM_W-1:0]     num;
   logic [TOTAL_W:0]     shifted;
   logic [7:0]           trial;
   logic [15:0]          trial_sq;
   logic                 out_free;
   logic [HALF_W-1:0]    p0, p1;

   assign pop        = (state_ff == ST_IDLE) && head_valid;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign out_free   = !rv_ff || rsp_tready;

   always_comb begin
      for (int j = 0; j < GENOTYPES; j++) begin
         if (j < HALF_GT)
            sums[j] = {1'b0, acc_lk_ff[j]} + {1'b0, ent_ff.lk0[8*j +: 8]};
         else
            sums[j] = {1'b0, acc_lk_ff[j]} + {1'b0, ent_ff.lk1[8*(j-HALF_GT) +: 8]};
      end
      mn = sums[0];
      for (int j = 1; j < GENOTYPES; j++)
         if (sums[j] < mn) mn = sums[j];
      for (int j = 0; j < HALF_GT; j++) begin
         p0[8*j +: 8] = acc_lk_ff[j];
         p1[8*j +: 8] = acc_lk_ff[j+HALF_GT];
      end
   end

   assign llk_sum  = {1'b0, acc_llk_ff} + {10'd0, mn} + {3'd0, ent_ff.llk};
   assign prod     = sqb_ff * ent_ff.dp;
   assign num      = {1'b0, pa_ff} + {3'd0, prod};
   assign shifted  = {rem_ff, quo_ff[SQ_W-1]};
   assign trial    = root_ff | (8'd1 << cnt_ff[2:0]);
   assign trial_sq = trial * trial;

   always_comb begin
      state_in   = state_ff;
      ent_in     = ent_ff;
      acc_lk_in  = acc_lk_ff;
      acc_dp_in  = acc_dp_ff;
      acc_q_in   = acc_q_ff;
      acc_llk_in = acc_llk_ff;
      base_in    = base_ff;
      open_in    = open_ff;
      total_in   = total_ff;
      sqa_in     = sqa_ff;
      sqb_in     = sqb_ff;
      pa_in      = pa_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      root_in    = root_ff;
      rd_in      = rd_ff;
      rv_in      = rsp_tready ? 1'b0 : rv_ff;
      diff       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               ent_in = head_data;
               if (!open_ff) begin
                  base_in = head_data.base;
                  open_in = 1'b1;
               end
               state_in = head_data.used ? ST_LK : ST_FIN;
            end
         end
         ST_LK: begin
            for (int j = 0; j < GENOTYPES; j++) begin
               diff = sums[j] - mn;
               acc_lk_in[j] = diff[LK_W] ? 8'hFF : diff[LK_W-1:0];
            end
            acc_llk_in = llk_sum[LLK_W] ? {LLK_W{1'b1}} : llk_sum[LLK_W-1:0];
            total_in   = {1'b0, acc_dp_ff} + {3'd0, ent_ff.dp};
            if (acc_dp_ff == '0 && ent_ff.dp == '0) begin
               acc_q_in = 8'd0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            sqa_in   = acc_q_ff * acc_q_ff;
            sqb_in   = ent_ff.mq * ent_ff.mq;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            pa_in    = sqa_ff * acc_dp_ff;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            // The mean never exceeds 255 squared, so the top bits start below the divisor.
            rem_in   = num[NUM_W-1:SQ_W];
            quo_in   = num[SQ_W-1:0];
            cnt_in   = 4'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (shifted >= {1'b0, total_ff}) begin
               rem_in = TOTAL_W'(shifted - {1'b0, total_ff});
               quo_in = {quo_ff[SQ_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[TOTAL_W-1:0];
               quo_in = {quo_ff[SQ_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               cnt_in   = 4'd7;
               root_in  = 8'd0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (trial_sq <= quo_ff) root_in = trial;
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd0) begin
               acc_q_in  = (trial_sq <= quo_ff) ? trial : root_ff;
               acc_dp_in = total_ff[TOTAL_W-1] ? {DEPTH_W{1'b1}} : total_ff[DEPTH_W-1:0];
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!ent_ff.last) begin
               state_in = ST_IDLE;
            end else if (acc_dp_ff == '0 || out_free) begin
               if (acc_dp_ff != '0) begin
                  rv_in = 1'b1;
                  rd_in = {1'b0, acc_llk_ff, acc_dp_ff, acc_q_ff, p1, p0, base_ff,
                           ent_ff.pos};
               end
               acc_lk_in  = '{default: '0};
               acc_dp_in  = '0;
               acc_q_in   = '0;
               acc_llk_in = '0;
               base_in    = '0;
               open_in    = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      total_ff <= total_in;
      sqa_ff   <= sqa_in;
      sqb_ff   <= sqb_in;
      pa_ff    <= pa_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      root_ff  <= root_in;
      rd_ff    <= rd_in;
      if (reset) begin
         state_ff   <= ST_IDLE;
         acc_lk_ff  <= '{default: '0};
         acc_dp_ff  <= '0;
         acc_q_ff   <= '0;
         acc_llk_ff <= '0;
         base_ff    <= '0;
         open_ff    <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         acc_lk_ff  <= acc_lk_in;
         acc_dp_ff  <= acc_dp_in;
         acc_q_ff   <= acc_q_in;
         acc_llk_ff <= acc_llk_in;
         base_ff    <= base_in;
         open_ff    <= open_in;
         rv_ff      <= rv_in;
      end
   end

   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < total_ff)) else $error("division remainder too large");
   a_emit_depth: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (rd_ff[148:123] != '0)) else $error("record emitted with zero depth");
   a_closed_after_emit: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !$past(rv_ff)) |-> !open_ff) else $error("site still open after emit");

endmodule

FILE: rtl/genotype_likelihood_merge_top.sv
// Merges per-source genotype likelihood records of one site; the record marked by
// req_tlast closes the site, and one merged record leaves on rsp_ when the merged depth
// is nonzero. Requests are accepted while the two-entry queue is not full. In the back
// end a record that fails its limits goes straight to the finish state, a passing
// record with zero combined depth passes the likelihood step first, and other passing
// records also run a 16-step restoring division and an 8-step square root on one shared
// sequencer; the back end then returns to idle for the next record in the queue. A
// closing record with nonzero merged depth waits until the previous one leaves on rsp_.
// The user must write limits on csr_ only while the block is idle; nothing checks it.
module genotype_likelihood_merge_top import gtlm_pkg::*; #(
   parameter int unsigned MAX_SOURCES = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // source_index, ref_base, site_position, lk_first_half, lk_second_half,
   // map_quality, read_depth, min_llk_in, zero fill
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // out_position, out_ref_base, out_lk_first_half, out_lk_second_half,
   // out_map_quality, out_depth, out_min_llk, zero fill
   output logic [TDATA_W-1:0] rsp_tdata,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [CSR_W-1:0]   csr_wdata
);

   entry_type entry, head_data;
   logic      full, pop, head_valid, push;

   assign req_tready = !full;
   assign push       = req_tvalid && !full;

   gtlm_front #(.MAX_SOURCES(MAX_SOURCES)) u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .req_tdata, .req_tlast, .entry
   );

   gtlm_queue u_queue (
      .clock, .reset, .push, .push_data(entry), .full, .pop, .head_valid, .head_data
   );

   gtlm_back u_back (
      .clock, .reset, .head_valid, .head_data, .pop, .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

endmodule

FILE: sim/genotype_likelihood_merge_top_tb.sv
module genotype_likelihood_merge_top_tb;
   import gtlm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]          src;
      logic [3:0]          base;
      logic [POS_W-1:0]    pos;
      logic [HALF_W-1:0]   lk0;
      logic [HALF_W-1:0]   lk1;
      logic [7:0]          mq;
      logic [DP_IN_W-1:0]  dp;
      logic [LLK_IN_W-1:0] llk;
      logic                last;
   } record_type;

   typedef struct {
      logic [POS_W-1:0]   pos;
      logic [3:0]         base;
      logic [HALF_W-1:0]  lk0;
      logic [HALF_W-1:0]  lk1;
      logic [7:0]         mq;
      logic [DEPTH_W-1:0] depth;
      logic [LLK_W-1:0]   llk;
   } merged_type;

   typedef struct {
      record_type rec;
      bit         typed;
      bit         typed_emit;
      merged_type typed_out;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [TDATA_W-1:0] req_tdata;
   logic               req_tlast;
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [TDATA_W-1:0] rsp_tdata;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   genotype_likelihood_merge_top u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow of the limits and of the site accumulators.
   logic [31:0]        lim_quality;
   logic [63:0]        lim_min_depth;
   logic [63:0]        lim_max_depth;
   logic [7:0]         site_lk[GENOTYPES];
   logic [DEPTH_W-1:0] site_depth;
   logic [7:0]         site_mq;
   logic [LLK_W-1:0]   site_llk;
   logic [3:0]         site_ref;
   bit                 site_busy;

   merged_type merged_q[$];
   int      mismatches;
   int      tx_idle;
   int      rx_idle;
   int      hold_cycles;
   bit      done;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [7:0] isqrt(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r[7:0];
   endfunction

   function automatic void clear_site();
      foreach (site_lk[j]) site_lk[j] = '0;
      site_depth = '0;
      site_mq = '0;
      site_llk = '0;
      site_ref = '0;
      site_busy = 1'b0;
   endfunction

   function automatic bit merge_record(record_type r, output merged_type o);
      logic [7:0]  qlim;
      logic [15:0] dmin;
      logic [15:0] dmax;
      logic [8:0]  sums[GENOTYPES];
      logic [8:0]  mn;
      logic [63:0] total;
      logic [63:0] num;
      logic [31:0] llk_sum;
      bit          emit;
      emit = 0;
      o = '{default: 0};
      if (!site_busy) begin
         site_ref = r.base;
         site_busy = 1;
      end
      qlim = lim_quality[8*r.src +: 8];
      dmin = lim_min_depth[16*r.src +: 16];
      dmax = lim_max_depth[16*r.src +: 16];
      if (r.mq >= qlim && r.dp >= dmin && (dmax == 0 || r.dp <= dmax)) begin
         for (int j = 0; j < GENOTYPES; j++) begin
            if (j < 5) sums[j] = {1'b0, site_lk[j]} + {1'b0, r.lk0[8*j +: 8]};
            else sums[j] = {1'b0, site_lk[j]} + {1'b0, r.lk1[8*(j-5) +: 8]};
         end
         mn = sums[0];
         for (int j = 1; j < GENOTYPES; j++)
            if (sums[j] < mn) mn = sums[j];
         for (int j = 0; j < GENOTYPES; j++)
            site_lk[j] = (sums[j] - mn) > 9'd255 ? 8'd255 : 8'(sums[j] - mn);
         llk_sum = 32'(site_llk) + 32'(mn) + 32'(r.llk);
         site_llk = llk_sum > 32'h3FFFF ? 18'h3FFFF : llk_sum[LLK_W-1:0];
         total = 64'(site_depth) + 64'(r.dp);
         if (total == 0) begin
            site_mq = '0;
         end else begin
            num = 64'(site_mq) * site_mq * site_depth + 64'(r.mq) * r.mq * r.dp;
            site_mq = isqrt(num / total);
         end
         site_depth = total > 64'h3FFFFFF ? 26'h3FFFFFF : total[DEPTH_W-1:0];
      end
      if (r.last) begin
         if (site_depth != 0) begin
            o.pos = r.pos;
            o.base = site_ref;
            for (int j = 0; j < 5; j++) begin
               o.lk0[8*j +: 8] = site_lk[j];
               o.lk1[8*j +: 8] = site_lk[j+5];
            end
            o.mq = site_mq;
            o.depth = site_depth;
            o.llk = site_llk;
            emit = 1;
         end
         clear_site();
      end
      return emit;
   endfunction

   // Drive one request; the expected merge is recorded at the accepting edge.
   task automatic send_record(record_type r, bit use_typed, bit typed_emit,
                              merged_type typed_out);
      merged_type o;
      bit      emit;
      @(negedge clock);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tlast <= r.last;
      req_tdata <= {3'b0, r.llk, r.dp, r.mq, r.lk1, r.lk0, r.pos, r.base, r.src};
      do @(posedge clock); while (!req_tready);
      emit = merge_record(r, o);
      if (use_typed) begin
         emit = typed_emit;
         o = typed_out;
      end
      if (emit) merged_q.push_back(o);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (merged_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_limits(logic [31:0] q, logic [63:0] dmin, logic [63:0] dmax);
      logic [1:0]       idx[3];
      logic [CSR_W-1:0] val[3];
      idx = '{CSR_QUALITY, CSR_MIN_DEPTH, CSR_MAX_DEPTH};
      val = '{64'(q), dmin, dmax};
      for (int k = 0; k < 3; k++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
      end
      @(negedge clock);
      csr_we <= 1'b0;
      lim_quality = q;
      lim_min_depth = dmin;
      lim_max_depth = dmax;
   endtask

   function automatic logic [HALF_W-1:0] rand_half();
      return {8'($urandom_range(255)), 32'($urandom())};
   endfunction

   function automatic record_type rand_record(logic [1:0] src, logic [POS_W-1:0] pos,
                                              bit last);
      record_type r;
      int      pick;
      r.src = src;
      r.base = 4'($urandom_range(15));
      r.pos = pos;
      r.lk0 = rand_half();
      r.lk1 = rand_half();
      if ($urandom_range(9) == 0) begin
         r.lk0 = '1;
         r.lk1 = $urandom_range(1) ? '1 : '0;
      end
      pick = $urandom_range(9);
      r.mq = pick < 4 ? 8'(lim_quality[8*src +: 8] + $urandom_range(4) - 2)
                      : 8'($urandom_range(255));
      pick = $urandom_range(19);
      if (pick == 0) r.dp = 24'($urandom_range(24'hFFFFFF));
      else if (pick < 3) r.dp = '0;
      else r.dp = 24'($urandom_range(300));
      r.llk = 16'($urandom_range(16'hFFFF));
      r.last = last;
      return r;
   endfunction

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      merged_type got;
      merged_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         {got.llk, got.depth, got.mq, got.lk1, got.lk0, got.base, got.pos} = rsp_tdata[166:0];
         if (merged_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected merged record %p", got);
         end else begin
            want = merged_q.pop_front();
            if (got.pos !== want.pos || got.base !== want.base || got.lk0 !== want.lk0
                || got.lk1 !== want.lk1 || got.mq !== want.mq
                || got.depth !== want.depth || got.llk !== want.llk) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("merged record differs: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type row;
      record_type    r;
      merged_type    none;
      int            nsites;
      logic [POS_W-1:0] pos;
      int            src;
      int            len;

      req_tvalid = 0;
      req_tlast = 0;
      req_tdata = '0;
      rsp_tready = 0;
      csr_we = 0;
      csr_index = CSR_QUALITY;
      csr_wdata = '0;
      tx_idle = 0;
      rx_idle = 0;
      hold_cycles = 0;
      mismatches = 0;
      none = '{default: 0};
      lim_quality = QUALITY_RST;
      lim_min_depth = MIN_DEPTH_RST;
      lim_max_depth = MAX_DEPTH_RST;
      clear_site();
      reset = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Single passing record at the quality and depth floors.
      row = '{rec: '{0, 4'h3, 31'd5, '0, '0, 8'd30, 24'd1, 16'd0, 1'b1},
              typed: 1, typed_emit: 1,
              typed_out: '{31'd5, 4'h3, '0, '0, 8'd30, 26'd1, 18'd0}};
      rows.push_back(row);
      // Saturated likelihoods normalize to zero and move into min_llk.
      row = '{rec: '{0, 4'hF, 31'h7FFFFFFF, '1, '1, 8'd255, 24'd200, 16'hFFFF, 1'b1},
              typed: 1, typed_emit: 1,
              typed_out: '{31'h7FFFFFFF, 4'hF, '0, '0, 8'd255, 26'd200, 18'd65790}};
      rows.push_back(row);
      // A failing record alone on its site produces nothing.
      row = '{rec: '{1, 4'h0, 31'd0, '1, '0, 8'd0, 24'd10, 16'd0, 1'b1},
              typed: 1, typed_emit: 0, typed_out: none};
      rows.push_back(row);
      // A four-source site with mixed pass/fail and differing positions.
      row = '{rec: '{0, 4'h5, 31'd100, 40'h0102030405, 40'hAA00FF1080, 8'd40, 24'd10,
                     16'd7, 1'b0}, typed: 0, typed_emit: 0, typed_out: none};
      rows.push_back(row);
      row.rec = '{1, 4'h6, 31'd100, '1, '1, 8'd200, 24'd201, 16'd1, 1'b0};
      rows.push_back(row);
      row.rec = '{2, 4'h7, 31'd101, '0, '1, 8'd200, 24'd0, 16'd1, 1'b0};
      rows.push_back(row);
      row.rec = '{3, 4'h8, 31'd102, 40'h55AA55AA55, 40'hFF00FF00FF, 8'd200, 24'd50,
                  16'hFFFF, 1'b1};
      rows.push_back(row);
      // Depth far above the cap fails; the site closes empty.
      row.rec = '{2, 4'h9, 31'd7, '0, '0, 8'd255, 24'hFFFFFF, 16'd0, 1'b1};
      rows.push_back(row);
      row.rec = '{3, 4'h1, 31'd8, 40'h8040201008, 40'h0102040810, 8'd30, 24'd200,
                  16'd300, 1'b0};
      rows.push_back(row);
      row.rec = '{3, 4'h2, 31'd8, 40'hFEDCBA9876, 40'h0123456789, 8'd31, 24'd199,
                  16'd300, 1'b1};
      rows.push_back(row);
      foreach (rows[i])
         send_record(rows[i].rec, rows[i].typed, rows[i].typed_emit, rows[i].typed_out);
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_limits(32'h00000000, 64'h0, 64'h0);
            1: write_limits(32'hFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
            2: write_limits(QUALITY_RST, MIN_DEPTH_RST, MAX_DEPTH_RST);
            3: write_limits(32'h0A141E28, 64'h0000000100020000, 64'h0000012C00000064);
            4: write_limits($urandom() & 32'h3F3F3F3F,
                            {$urandom(), $urandom()} & 64'h000F000F000F000F,
                            {$urandom(), $urandom()} & 64'h01FF01FF01FF01FF);
            default: write_limits(32'h00FF0010, 64'h0, 64'h0000FFFF00000000);
         endcase
         tx_idle = phase < 2 ? 12 : (phase < 4 ? 86 : 0);
         rx_idle = phase < 2 ? 86 : (phase < 4 ? 12 : 0);
         if (phase == 4) hold_cycles = 600;
         nsites = 0;
         while (nsites < 165) begin
            pos = 31'($urandom_range(31'h7FFFFFFF));
            if ($urandom_range(9) == 0) begin
               // Noise: arbitrary sources, occasionally a long run that saturates depth.
               len = $urandom_range(1, 6);
               for (int k = 0; k < len; k++) begin
                  r = rand_record(2'($urandom_range(3)),
                                  31'($urandom_range(31'h7FFFFFFF)), k == len - 1);
                  if (phase == 0 && $urandom_range(1))
                     r.dp = 24'hFFFFF0 | 24'($urandom_range(15));
                  if ($urandom_range(3) == 0) r.llk = 16'hFFFF;
                  send_record(r, 0, 0, none);
               end
            end else begin
               src = $urandom_range(3);
               while (src < 4) begin
                  r = rand_record(2'(src), pos, 0);
                  src = src + $urandom_range(1, 2);
                  r.last = src >= 4 || $urandom_range(4) == 0;
                  send_record(r, 0, 0, none);
                  if (r.last) src = 4;
               end
            end
            nsites++;
         end
         wait_idle();
      end

      if (mismatches == 0 && merged_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/gtlm_pkg.sv
rtl/gtlm_front.sv
rtl/gtlm_queue.sv
rtl/gtlm_back.sv
rtl/genotype_likelihood_merge_top.sv
sim/genotype_likelihood_merge_top_tb.sv
